[sv/b2s_pkg.sv]
// Package: shared constants, types and functions for the BLAKE2s keyed hash.
`timescale 1ns / 1ps
package b2s_pkg;

    localparam int DIGEST_BYTES_MAX = 32;
    localparam int KEY_BYTES_MAX    = 32;
    localparam int CFG_ADDR_W       = 3;
    localparam int CFG_DATA_W       = 64;

    localparam logic [CFG_ADDR_W-1:0] REG_DIGEST_LEN = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_LEN    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY0       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY1       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY2       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY3       = 3'd5;

    localparam logic [31:0] PARAM_BASE = 32'h0101_0000;

    typedef logic [31:0] word_t;

    // controller -> datapath commands
    typedef struct packed {
        logic       start_msg;   // load IV/param, key block
        logic       push_word;   // append current input bytes
        logic       flush_full;  // compress full buffer (not final)
        logic       pad_final;   // add fill to counter, prepare final
        logic       comp_init;   // load v from h
        logic       comp_step;   // one G step
        logic       comp_done;   // fold v into h
        logic       final_blk;   // last-block flag for comp_init
        logic       clear_msg;   // clear buffer/counter
        logic [2:0] byte_take;   // bytes to append this push
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic       buf_full;
        logic [6:0] fill;
        logic [5:0] dlen;
    } stat_t;

    function automatic word_t iv_word(input logic [2:0] i);
        word_t r;
        case (i)
            3'd0: r = 32'h6A09E667;
            3'd1: r = 32'hBB67AE85;
            3'd2: r = 32'h3C6EF372;
            3'd3: r = 32'hA54FF53A;
            3'd4: r = 32'h510E527F;
            3'd5: r = 32'h9B05688C;
            3'd6: r = 32'h1F83D9AB;
            default: r = 32'h5BE0CD19;
        endcase
        return r;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

[sv/b2s_ctrl.sv]
// Controller: sequences message intake, compressions and digest output.
`timescale 1ns / 1ps
module b2s_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        byte_count,
    input  logic              last_word,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        digest_index,
    output logic              last_digest_word,
    output b2s_pkg::cmd_t     cmd,
    input  b2s_pkg::stat_t    stat
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_COMP = 3'd1;
    localparam logic [2:0] ST_PUSH = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;
    localparam logic [2:0] ST_INIT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [6:0] step_reg, step_next;   // 80 G steps
    logic       fin_reg, fin_next;
    logic       open_reg, open_next;
    logic       lastw_reg, lastw_next;
    logic [2:0] take_reg, take_next;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] nw_m1;
    logic [2:0] cnt_sat;
    logic [6:0] room;
    logic [2:0] take_fit;

    assign cnt_sat = (byte_count > 3'd4) ? 3'd4 : byte_count;
    assign nw_m1   = 3'((stat.dlen + 6'd3) >> 2) - 3'd1;

    // bytes that still fit in the buffer; the rest waits for a flush
    assign room     = 7'd64 - stat.fill;
    assign take_fit = ({4'd0, take_reg} > room) ? room[2:0] : take_reg;

    assign in_ready         = (state_reg == ST_IDLE);
    assign out_valid        = (state_reg == ST_OUT);
    assign digest_index     = idx_reg;
    assign last_digest_word = (idx_reg == nw_m1);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        fin_next   = fin_reg;
        open_next  = open_reg;
        lastw_next = lastw_reg;
        take_next  = take_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.byte_take = take_fit;
        cmd.final_blk = fin_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    take_next  = cnt_sat;
                    lastw_next = last_word;
                    if (!open_reg)
                    begin
                        cmd.start_msg = 1'b1;
                        open_next = 1'b1;
                    end
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (take_reg != 3'd0 && stat.buf_full)
                begin
                    cmd.flush_full = 1'b1;
                    fin_next   = 1'b0;
                    state_next = ST_INIT;
                end
                else
                begin
                    cmd.push_word = 1'b1;
                    take_next = take_reg - take_fit;
                    if (take_reg != take_fit)
                        state_next = ST_PUSH;
                    else if (lastw_reg)
                    begin
                        cmd.pad_final = 1'b1;
                        fin_next   = 1'b1;
                        state_next = ST_INIT;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_INIT:
            begin
                cmd.comp_init = 1'b1;
                step_next  = '0;
                state_next = ST_COMP;
            end
            ST_COMP:
            begin
                cmd.comp_step = 1'b1;
                step_next = step_reg + 7'd1;
                if (step_reg == 7'd79)
                begin
                    cmd.comp_done = 1'b1;
                    if (fin_reg)
                    begin
                        idx_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                        state_next = ST_PUSH;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == nw_m1)
                    begin
                        cmd.clear_msg = 1'b1;
                        open_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            fin_reg   <= 1'b0;
            open_reg  <= 1'b0;
            lastw_reg <= 1'b0;
            take_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            fin_reg   <= fin_next;
            open_reg  <= open_next;
            lastw_reg <= lastw_next;
            take_reg  <= take_next;
            idx_reg   <= idx_next;
        end
    end
endmodule

[sv/b2s_dp.sv]
// Datapath: config registers, buffer, counter, chain value and one G unit.
`timescale 1ns / 1ps
module b2s_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_addr,
    input  logic [63:0]         cfg_data,
    input  logic                in_accept,
    input  logic [31:0]         data_word,
    input  b2s_pkg::cmd_t       cmd,
    output b2s_pkg::stat_t      stat,
    input  logic [2:0]          digest_index,
    output logic [31:0]         digest_word
);
    logic [5:0]  dl_cfg_reg, kl_cfg_reg;
    logic [63:0] key_reg [4];
    logic [31:0] h_reg [8];
    logic [31:0] m_reg [16];
    logic [31:0] v_reg [16];
    logic [63:0] t_reg;
    logic [6:0]  fill_reg;
    logic [5:0]  dlen_reg;
    logic [31:0] word_reg;
    logic [6:0]  g_reg;      // G step counter: round*8+g
    logic [5:0]  dl_eff, kl_eff;

    assign dl_eff = (dl_cfg_reg == 6'd0) ? 6'd1 :
                    (dl_cfg_reg > 6'd32) ? 6'd32 : dl_cfg_reg;
    assign kl_eff = (kl_cfg_reg > 6'd32) ? 6'd32 : kl_cfg_reg;

    assign stat.buf_full = (fill_reg >= 7'd64);
    assign stat.fill     = fill_reg;
    assign stat.dlen     = dlen_reg;

    // G operand selection
    logic [3:0] ia, ib, ic, id, rnd, sx, sy;
    logic [2:0] gi;
    logic [31:0] a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2, mx, my;
    logic [3:0] sig_tab [10][16];

    always_comb
    begin
        sig_tab = '{
            '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15},
            '{4'd14,4'd10,4'd4,4'd8,4'd9,4'd15,4'd13,4'd6,4'd1,4'd12,4'd0,4'd2,4'd11,4'd7,4'd5,4'd3},
            '{4'd11,4'd8,4'd12,4'd0,4'd5,4'd2,4'd15,4'd13,4'd10,4'd14,4'd3,4'd6,4'd7,4'd1,4'd9,4'd4},
            '{4'd7,4'd9,4'd3,4'd1,4'd13,4'd12,4'd11,4'd14,4'd2,4'd6,4'd5,4'd10,4'd4,4'd0,4'd15,4'd8},
            '{4'd9,4'd0,4'd5,4'd7,4'd2,4'd4,4'd10,4'd15,4'd14,4'd1,4'd11,4'd12,4'd6,4'd8,4'd3,4'd13},
            '{4'd2,4'd12,4'd6,4'd10,4'd0,4'd11,4'd8,4'd3,4'd4,4'd13,4'd7,4'd5,4'd15,4'd14,4'd1,4'd9},
            '{4'd12,4'd5,4'd1,4'd15,4'd14,4'd13,4'd4,4'd10,4'd0,4'd7,4'd6,4'd3,4'd9,4'd2,4'd8,4'd11},
            '{4'd13,4'd11,4'd7,4'd14,4'd12,4'd1,4'd3,4'd9,4'd5,4'd0,4'd15,4'd4,4'd8,4'd6,4'd2,4'd10},
            '{4'd6,4'd15,4'd14,4'd9,4'd11,4'd3,4'd0,4'd8,4'd12,4'd2,4'd13,4'd7,4'd1,4'd4,4'd10,4'd5},
            '{4'd10,4'd2,4'd8,4'd4,4'd7,4'd6,4'd1,4'd5,4'd15,4'd11,4'd9,4'd14,4'd3,4'd12,4'd13,4'd0}};
        rnd = g_reg[6:3];
        gi  = g_reg[2:0];
        case (gi)
            3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
            3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
            3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
            3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
            3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
            3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
            3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
            default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
        endcase
        sx = sig_tab[(rnd > 4'd9) ? 4'd9 : rnd][{gi, 1'b0}];
        sy = sig_tab[(rnd > 4'd9) ? 4'd9 : rnd][{gi, 1'b1}];
        mx = m_reg[sx];
        my = m_reg[sy];
        a0 = v_reg[ia] + v_reg[ib] + mx;
        d0 = b2s_pkg::rotr(v_reg[id] ^ a0, 16);
        c0 = v_reg[ic] + d0;
        b0 = b2s_pkg::rotr(v_reg[ib] ^ c0, 12);
        a1 = a0 + b0 + my;
        d1 = b2s_pkg::rotr(d0 ^ a1, 8);
        c1 = c0 + d1;
        b1 = b2s_pkg::rotr(b0 ^ c1, 7);
        a2 = a1; b2 = b1; c2 = c1; d2 = d1;
    end

    logic [31:0] dw;
    logic [5:0]  rem;
    always_comb
    begin
        dw  = h_reg[digest_index];
        rem = dlen_reg - {1'b0, digest_index, 2'b00};
        if (rem < 6'd4)
            dw = dw & ((32'd1 << {rem[1:0], 3'b000}) - 32'd1);
    end
    assign digest_word = dw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dl_cfg_reg <= 6'd32;
            kl_cfg_reg <= 6'd0;
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= b2s_pkg::iv_word(3'(i))
                            ^ ((i == 0) ? 32'h0101_0020 : 32'd0);
            for (int i = 0; i < 16; i++) m_reg[i] <= '0;
            for (int i = 0; i < 16; i++) v_reg[i] <= '0;
            t_reg    <= '0;
            fill_reg <= '0;
            dlen_reg <= 6'd32;
            word_reg <= '0;
            g_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    b2s_pkg::REG_DIGEST_LEN: dl_cfg_reg <= cfg_data[5:0];
                    b2s_pkg::REG_KEY_LEN:    kl_cfg_reg <= cfg_data[5:0];
                    b2s_pkg::REG_KEY0:       key_reg[0] <= cfg_data;
                    b2s_pkg::REG_KEY1:       key_reg[1] <= cfg_data;
                    b2s_pkg::REG_KEY2:       key_reg[2] <= cfg_data;
                    b2s_pkg::REG_KEY3:       key_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
            if (in_accept)
                word_reg <= data_word;
            if (cmd.start_msg)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= b2s_pkg::iv_word(3'(i))
                                ^ ((i == 0) ? (b2s_pkg::PARAM_BASE
                                   | {18'd0, kl_eff, 2'b00, dl_eff}) : 32'd0);
                dlen_reg <= dl_eff;
                t_reg    <= '0;
                for (int i = 0; i < 8; i++)
                    for (int j = 0; j < 4; j++)
                        m_reg[i][j*8 +: 8] <= ((i*4 + j) < int'(kl_eff))
                            ? key_reg[i/2][((i%2)*4 + j)*8 +: 8] : 8'd0;
                for (int i = 8; i < 16; i++) m_reg[i] <= '0;
                fill_reg <= (kl_eff != 6'd0) ? 7'd64 : 7'd0;
            end
            if (cmd.flush_full)
            begin
                t_reg <= t_reg + 64'd64;
            end
            if (cmd.push_word)
            begin
                // byte_take never runs past the end of the buffer
                for (int j = 0; j < 4; j++)
                    if (j < int'(cmd.byte_take))
                        m_reg[4'((fill_reg + 7'(j)) >> 2)][((fill_reg + 7'(j)) & 7'd3)*8 +: 8]
                            <= word_reg[j*8 +: 8];
                word_reg <= word_reg >> {cmd.byte_take, 3'b000};
                fill_reg <= fill_reg + 7'(cmd.byte_take);
                if (cmd.pad_final)
                begin
                    for (int k = 0; k < 64; k++)
                        if (k >= int'(fill_reg) + int'(cmd.byte_take))
                            m_reg[k/4][(k%4)*8 +: 8] <= 8'd0;
                    t_reg <= t_reg + 64'(fill_reg) + 64'(cmd.byte_take);
                end
            end
            if (cmd.comp_init)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i]   <= h_reg[i];
                    v_reg[i+8] <= b2s_pkg::iv_word(3'(i));
                end
                v_reg[12] <= b2s_pkg::iv_word(3'd4) ^ t_reg[31:0];
                v_reg[13] <= b2s_pkg::iv_word(3'd5) ^ t_reg[63:32];
                v_reg[14] <= b2s_pkg::iv_word(3'd6) ^ {32{cmd.final_blk}};
                g_reg <= '0;
            end
            if (cmd.comp_step)
            begin
                v_reg[ia] <= a2; v_reg[ib] <= b2;
                v_reg[ic] <= c2; v_reg[id] <= d2;
                g_reg <= g_reg + 7'd1;
            end
            if (cmd.comp_done)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] ^ v_reg[i] ^ v_reg[i+8]
                        ^ ((ia == 4'(i)) ? (v_reg[i] ^ a2) : 32'd0)
                        ^ ((ib == 4'(i)) ? (v_reg[i] ^ b2) : 32'd0)
                        ^ ((ic == 4'(i+8)) ? (v_reg[i+8] ^ c2) : 32'd0)
                        ^ ((id == 4'(i+8)) ? (v_reg[i+8] ^ d2) : 32'd0);
                if (!cmd.final_blk)
                    fill_reg <= '0;
            end
            if (cmd.clear_msg)
            begin
                for (int i = 0; i < 16; i++) m_reg[i] <= '0;
                t_reg    <= '0;
                fill_reg <= '0;
            end
        end
    end
endmodule

[sv/blake2s_keyed_hash.sv]
// Top level: BLAKE2s keyed hash, controller plus datapath.
// A word that fills no block only goes into the buffer; a word that forces a
// compression waits for it (one G function per cycle, 80 steps), and when its
// bytes straddle the block boundary, the rest are pushed after it.
// The last word adds one compression, then 1 to 8 digest words.
// in_ready stays low until the block is through with the previous word.
// Reset (async, active low): digest length 32, unkeyed, no message open.
`timescale 1ns / 1ps
module blake2s_keyed_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        last_digest_word
);
    b2s_pkg::cmd_t  cmd;
    b2s_pkg::stat_t stat;

    // controller owns the request handshakes and sequencing
    b2s_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .byte_count(byte_count), .last_word(last_word),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_index(digest_index), .last_digest_word(last_digest_word),
        .cmd(cmd), .stat(stat)
    );

    // datapath holds the config, buffer and hash state and the shared G unit
    b2s_dp u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .in_accept(in_valid & in_ready), .data_word(data_word),
        .cmd(cmd), .stat(stat),
        .digest_index(digest_index), .digest_word(digest_word)
    );
endmodule

[bench/blake2s_keyed_hash_tb.sv]
// Testbench: randomized and directed regression of the BLAKE2s keyed hash block.
`timescale 1ns / 1ps
module blake2s_keyed_hash_tb;

    // Digest word as seen on the result port.
    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_rec_t;

    // Scoreboard: holds the expected digest words in arrival order.
    class digest_board;
        digest_rec_t pending[$];
        int          errors;

        function void note_request(digest_rec_t r);
            pending.push_back(r);
        endfunction

        function void check_digest(digest_rec_t got);
            digest_rec_t want;
            if (pending.size() == 0)
            begin
                $error("digest word with nothing pending: %h", got.word);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.word !== want.word)
            begin
                $error("digest_word exp %h got %h", want.word, got.word);
                errors++;
            end
            if (got.index !== want.index)
            begin
                $error("digest_index exp %0d got %0d", want.index, got.index);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last_digest_word exp %0d got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    localparam int TIMEOUT_CYCLES = 2_000_000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        last_digest_word;

    blake2s_keyed_hash dut (.*);

    digest_board board;

    // ---------------- predictor state ----------------
    // Configuration as written, before the block samples it at message start.
    logic [5:0]  cfg_dlen;
    logic [5:0]  cfg_klen;
    logic [63:0] cfg_key [4];
    // Hash state.
    logic [31:0] hstate [8];
    logic [63:0] msg_count;
    logic [31:0] blk [16];
    int          fill;
    bit          in_msg;
    int          dlen_live;

    // Message schedule, one row per round.
    function automatic int sched(int r, int p);
        int s[10][16] = '{
            '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
            '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
            '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
            '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
            '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
            '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
            '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
            '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
            '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
            '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};
        return s[r][p];
    endfunction

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void g_mix(ref logic [31:0] v[16], input int a, int b, int c,
                                  int d, logic [31:0] x, logic [31:0] y);
        v[a] = v[a] + v[b] + x;
        v[d] = ror(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = ror(v[b] ^ v[c], 12);
        v[a] = v[a] + v[b] + y;
        v[d] = ror(v[d] ^ v[a], 8);
        v[c] = v[c] + v[d];
        v[b] = ror(v[b] ^ v[c], 7);
    endfunction

    function automatic void compress_block(bit final_blk);
        logic [31:0] v [16];
        for (int i = 0; i < 8; i++)
        begin
            v[i]     = hstate[i];
            v[i + 8] = b2s_pkg::iv_word(i[2:0]);
        end
        v[12] ^= msg_count[31:0];
        v[13] ^= msg_count[63:32];
        if (final_blk)
            v[14] = ~v[14];
        for (int r = 0; r < 10; r++)
        begin
            g_mix(v, 0, 4, 8, 12, blk[sched(r, 0)], blk[sched(r, 1)]);
            g_mix(v, 1, 5, 9, 13, blk[sched(r, 2)], blk[sched(r, 3)]);
            g_mix(v, 2, 6, 10, 14, blk[sched(r, 4)], blk[sched(r, 5)]);
            g_mix(v, 3, 7, 11, 15, blk[sched(r, 6)], blk[sched(r, 7)]);
            g_mix(v, 0, 5, 10, 15, blk[sched(r, 8)], blk[sched(r, 9)]);
            g_mix(v, 1, 6, 11, 12, blk[sched(r, 10)], blk[sched(r, 11)]);
            g_mix(v, 2, 7, 8, 13, blk[sched(r, 12)], blk[sched(r, 13)]);
            g_mix(v, 3, 4, 9, 14, blk[sched(r, 14)], blk[sched(r, 15)]);
        end
        for (int i = 0; i < 8; i++)
            hstate[i] ^= v[i] ^ v[i + 8];
    endfunction

    function automatic void put_byte(int pos, logic [7:0] b);
        blk[(pos >> 2) & 15][(pos & 3) * 8 +: 8] = b;
    endfunction

    function automatic void clear_block();
        for (int i = 0; i < 16; i++)
            blk[i] = '0;
    endfunction

    // Block samples the registers here, not at write time.
    function automatic void open_message();
        int dl;
        int kl;
        dl = (cfg_dlen == 0) ? 1 : (cfg_dlen > 32 ? 32 : cfg_dlen);
        kl = (cfg_klen > 32) ? 32 : cfg_klen;
        for (int i = 0; i < 8; i++)
            hstate[i] = b2s_pkg::iv_word(i[2:0]);
        hstate[0] ^= b2s_pkg::PARAM_BASE | (kl << 8) | dl;
        dlen_live = dl;
        msg_count = '0;
        fill      = 0;
        clear_block();
        if (kl > 0)
        begin
            for (int i = 0; i < kl; i++)
                put_byte(i, cfg_key[i >> 3][(i & 7) * 8 +: 8]);
            fill = 64;
        end
        in_msg = 1;
    endfunction

    // A full buffer is compressed only when one more byte shows up.
    function automatic void append_byte(logic [7:0] b);
        if (fill >= 64)
        begin
            msg_count += 64;
            compress_block(0);
            fill = 0;
        end
        put_byte(fill, b);
        fill++;
    endfunction

    // Works out the digest words caused by one accepted request.
    function automatic void hash_request(logic [31:0] w, logic [2:0] cnt, logic lst);
        int n;
        int nw;
        int vb;
        digest_rec_t r;
        n = (cnt > 4) ? 4 : cnt;
        if (!in_msg)
            open_message();
        for (int i = 0; i < n; i++)
            append_byte(w[i * 8 +: 8]);
        if (!lst)
            return;
        for (int i = fill; i < 64; i++)
            put_byte(i, 8'h00);
        msg_count += fill;
        compress_block(1);
        nw = (dlen_live + 3) / 4;
        for (int i = 0; i < nw; i++)
        begin
            r.word = hstate[i];
            vb = dlen_live - i * 4;
            if (vb < 4)
                r.word &= (32'h1 << (vb * 8)) - 1;
            r.index = i[2:0];
            r.last  = (i + 1 == nw);
            board.note_request(r);
        end
        msg_count = '0;
        fill      = 0;
        clear_block();
        in_msg = 0;
    endfunction

    // ---------------- clock, reset, timeout ----------------
    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    int cycle_count;
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > TIMEOUT_CYCLES)
            begin
                $display("blake2s_keyed_hash regression: fail");
                $finish;
            end
        end
    end

    // ---------------- receiver ----------------
    // Stall pattern: mode 0 always ready, 1 random, 2 mostly stalled.
    // A long hold-off can be requested by the stimulus side.
    int  rx_mode;
    int  hold_cycles;
    always @(posedge clk)
    begin
        digest_rec_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.word  = digest_word;
            got.index = digest_index;
            got.last  = last_digest_word;
            board.check_digest(got);
        end
    end

    initial
    begin
        out_ready = 0;
        rx_mode   = 0;
        hold_cycles = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 0;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                    rx_mode = $urandom_range(0, 2);
                case (rx_mode)
                    0: out_ready <= 1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // ---------------- sender tasks ----------------
    int burst_left;

    task automatic send_word(logic [31:0] w, logic [2:0] cnt, logic lst);
        int gap;
        // Bursts with random gaps in between.
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        in_valid   = 1;
        data_word  = w;
        byte_count = cnt;
        last_word  = lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        hash_request(w, cnt, lst);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic write_reg(logic [2:0] addr, logic [63:0] val);
        cfg_we   = 1;
        cfg_addr = addr;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 0;
        case (addr)
            b2s_pkg::REG_DIGEST_LEN: cfg_dlen = val[5:0];
            b2s_pkg::REG_KEY_LEN:    cfg_klen = val[5:0];
            b2s_pkg::REG_KEY0:       cfg_key[0] = val;
            b2s_pkg::REG_KEY1:       cfg_key[1] = val;
            b2s_pkg::REG_KEY2:       cfg_key[2] = val;
            default:                 cfg_key[3] = val;
        endcase
    endtask

    // Waits for all digests, plus the compression latency for safety.
    task automatic drain();
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    // Sends a message of nbytes random bytes, last word possibly short.
    task automatic send_message(int nbytes);
        int left;
        int c;
        left = nbytes;
        if (left == 0)
        begin
            send_word($urandom, 3'd0, 1);
            return;
        end
        while (left > 0)
        begin
            c = (left > 4) ? 4 : left;
            left -= c;
            send_word($urandom, c[2:0], left == 0);
        end
    endtask

    task automatic random_setting();
        write_reg(b2s_pkg::REG_DIGEST_LEN, 64'($urandom_range(0, 63)));
        write_reg(b2s_pkg::REG_KEY_LEN,
                  64'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 63)));
        write_reg(b2s_pkg::REG_KEY0, {$urandom, $urandom});
        write_reg(b2s_pkg::REG_KEY1, {$urandom, $urandom});
        write_reg(b2s_pkg::REG_KEY2, {$urandom, $urandom});
        write_reg(b2s_pkg::REG_KEY3, {$urandom, $urandom});
    endtask

    // ---------------- main sequence ----------------
    initial
    begin
        int items;
        int len;
        board = new();
        rst_n = 0;
        cfg_we = 0; cfg_addr = b2s_pkg::REG_DIGEST_LEN; cfg_data = '0;
        in_valid = 0; data_word = '0; byte_count = '0; last_word = 0;
        cfg_dlen = 6'd32; cfg_klen = '0;
        for (int i = 0; i < 4; i++)
            cfg_key[i] = '0;
        in_msg = 0; fill = 0; msg_count = '0; dlen_live = 32;
        for (int i = 0; i < 8; i++)
            hstate[i] = '0;
        clear_block();
        burst_left = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: empty unkeyed message with reset settings.
        send_word(32'hFFFF_FFFF, 3'd0, 1);
        // Zero-count filler, oversize count, short non-last word, all-ones data.
        send_word(32'h0000_0000, 3'd0, 0);
        send_word(32'hFFFF_FFFF, 3'd7, 0);
        send_word(32'hA5A5_A5A5, 3'd1, 0);
        send_word(32'h1234_5678, 3'd3, 0);
        send_word(32'h0000_0000, 3'd4, 0);
        send_word(32'hDEAD_BEEF, 3'd2, 1);
        drain();
        // Extremes: digest length 0 and 63 saturate, key length 63, full key.
        write_reg(b2s_pkg::REG_DIGEST_LEN, 64'd0);
        write_reg(b2s_pkg::REG_KEY_LEN, 64'd63);
        write_reg(b2s_pkg::REG_KEY0, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(b2s_pkg::REG_KEY1, 64'h0);
        write_reg(b2s_pkg::REG_KEY2, 64'h0123_4567_89AB_CDEF);
        write_reg(b2s_pkg::REG_KEY3, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(32'h0, 3'd0, 1);            // keyed empty message
        send_message(64);                     // exactly one block
        drain();
        write_reg(b2s_pkg::REG_DIGEST_LEN, 64'd63);
        write_reg(b2s_pkg::REG_KEY_LEN, 64'd1);
        send_message(65);                     // crosses a block boundary
        // Register write mid-message applies to the next message only.
        send_word($urandom, 3'd4, 0);
        drain();
        write_reg(b2s_pkg::REG_DIGEST_LEN, 64'd5);
        write_reg(b2s_pkg::REG_KEY_LEN, 64'd0);
        send_word($urandom, 3'd4, 1);
        send_message(3);
        drain();
        items = 40;

        // Long receiver hold-off while the sender keeps offering requests.
        write_reg(b2s_pkg::REG_DIGEST_LEN, 64'd32);
        hold_cycles = 3000;
        for (int m = 0; m < 4; m++)
            send_message(8);
        items += 8;
        drain();

        // Random phases with changing settings.
        while (items < 270)
        begin
            random_setting();
            for (int m = 0; m < 4 && items < 270; m++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // Noise: unusual counts, non-last short words.
                    for (int k = $urandom_range(1, 6); k > 0; k--)
                    begin
                        send_word($urandom, 3'($urandom_range(0, 7)), 0);
                        items++;
                    end
                    send_word($urandom, 3'($urandom_range(0, 7)), 1);
                    items++;
                end
                else
                begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 140)
                                                       : $urandom_range(0, 20);
                    send_message(len);
                    items += (len + 3) / 4 + (len == 0);
                end
            end
            // Sender pauses until all pending digests are back.
            drain();
        end

        drain();
        if (board.errors == 0)
            $display("blake2s_keyed_hash regression: pass");
        else
            $display("blake2s_keyed_hash regression: fail");
        $finish;
    end
endmodule

[blake2s_keyed_hash.f]
sv/b2s_pkg.sv
sv/b2s_ctrl.sv
sv/b2s_dp.sv
sv/blake2s_keyed_hash.sv
bench/blake2s_keyed_hash_tb.sv
